### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`define ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NEXT(lbl, ante, cons)
`define ASSERT_NOW(lbl, ante, cons)
`endif
`endif

### design/fmwf_pkg.sv
// ----------------------------------------------------------------------------
// FM register write filter package
// Types, register codes and decode functions shared by the filter modules.
// ----------------------------------------------------------------------------
package fmwf_pkg;

    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_LEVELS = 2'd1;
    localparam logic [1:0] FUNC_PANS   = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic [1:0] EMU_GEN2 = 2'd1;
    localparam logic [1:0] EMU_GEN1 = 2'd2;

    localparam logic [1:0] CFG_EMU     = 2'd0;
    localparam logic [1:0] CFG_MUTE    = 2'd1;
    localparam logic [1:0] CFG_SILENCE = 2'd2;
    localparam logic [1:0] CFG_FADE    = 2'd3;

    localparam logic [7:0] REG_TEST    = 8'h01;
    localparam logic [7:0] REG_FOUROP  = 8'h04;
    localparam logic [7:0] REG_MODE    = 8'h05;
    localparam logic [7:0] REG_LVL_LO  = 8'h40;
    localparam logic [7:0] REG_LVL_HI  = 8'h55;
    localparam logic [7:0] REG_DRUM    = 8'hbd;
    localparam logic [7:0] REG_CONN_LO = 8'hc0;
    localparam logic [7:0] REG_CONN_HI = 8'hc8;
    localparam logic [7:0] REG_WAVE_LO = 8'he0;
    localparam logic [7:0] REG_WAVE_HI = 8'hf5;

    localparam logic [7:0] PAN_RESET = 8'h30;
    localparam logic [5:0] LVL_MAX   = 6'h3f;
    localparam logic [4:0] OP_LAST   = 5'd17;
    localparam logic [4:0] CH_LAST   = 5'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_LVL_RD,
        S_LVL_EV,
        S_PAN,
        S_FINAL,
        S_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic apply;
        logic lvl_rd;
        logic lvl_ev;
        logic pan_step;
        logic final_push;
        logic flush;
    } fmwf_cmd_t;

    typedef struct packed {
        logic [1:0] req_func;
        logic       req_bank_ok;
        logic       refresh;
        logic       lvl_last;
        logic       pan_last;
        logic       is_write;
    } fmwf_sts_t;

    typedef struct packed {
        logic [2:0] d3;
        logic [1:0] m3;
        logic [1:0] d6;
        logic [2:0] m6;
    } op_split_t;

    function automatic op_split_t split_op(input logic [4:0] off);
        op_split_t s;
        logic [4:0] t;
        if (off >= 5'd15) s.d3 = 3'd5;
        else if (off >= 5'd12) s.d3 = 3'd4;
        else if (off >= 5'd9) s.d3 = 3'd3;
        else if (off >= 5'd6) s.d3 = 3'd2;
        else if (off >= 5'd3) s.d3 = 3'd1;
        else s.d3 = 3'd0;
        t = off - {s.d3, 1'b0} - {2'b0, s.d3};
        s.m3 = t[1:0];
        if (off >= 5'd12) s.d6 = 2'd2;
        else if (off >= 5'd6) s.d6 = 2'd1;
        else s.d6 = 2'd0;
        t = off - {1'b0, s.d6, 2'b0} - {2'b0, s.d6, 1'b0};
        s.m6 = t[2:0];
        return s;
    endfunction

    function automatic logic [3:0] out_mask(input logic [2:0] algo);
        logic [3:0] m;
        unique case (algo)
            3'd0:    m = 4'h2;
            3'd1:    m = 4'h3;
            3'd2:    m = 4'h8;
            3'd3:    m = 4'h9;
            3'd4:    m = 4'hA;
            3'd5:    m = 4'hD;
            default: m = 4'h0;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] chan_algo(input logic bank, input logic [3:0] off9,
                                             input logic [5:0] fe, input logic [17:0] conn);
        logic [1:0] lo;
        logic [4:0] base;
        logic [2:0] fidx;
        logic [2:0] res;
        base = bank ? 5'd9 : 5'd0;
        lo = (off9 >= 4'd3) ? 2'(off9 - 4'd3) : off9[1:0];
        fidx = (bank ? 3'd3 : 3'd0) + {1'b0, lo};
        if ((off9 < 4'd6) && fe[fidx]) begin
            res = 3'd2 + {1'b0, conn[base + {3'b0, lo} + 5'd3], 1'b0}
                + {2'b0, conn[base + {3'b0, lo}]};
        end else begin
            res = {2'b0, conn[base + {1'b0, off9}]};
        end
        return res;
    endfunction

    function automatic logic is_output(input logic bank, input logic [4:0] off,
                                       input logic [5:0] fe, input logic [17:0] conn,
                                       input logic drum);
        op_split_t s;
        logic [2:0] fidx;
        logic [3:0] off9;
        logic [1:0] op;
        logic [3:0] m;
        s = split_op(off);
        fidx = (bank ? 3'd3 : 3'd0) + {1'b0, s.m3};
        if ((off < 5'd12) && fe[fidx]) begin
            off9 = {2'b0, s.m3};
            op = s.d3[1:0];
        end else begin
            off9 = {s.d6, 1'b0} + {2'b0, s.d6} + {2'b0, s.m3};
            op = (s.m6 >= 3'd3) ? 2'd1 : 2'd0;
        end
        m = out_mask(chan_algo(bank, off9, fe, conn));
        return (drum && !bank && (off >= 5'd12)) || m[op];
    endfunction

    function automatic logic [7:0] level_reg(input logic [4:0] off);
        op_split_t s;
        s = split_op(off);
        return REG_LVL_LO + {3'b0, s.d6, 3'b0} + {5'b0, s.m6};
    endfunction

    function automatic logic [7:0] apply_fade(input logic [7:0] lv, input logic [5:0] fa);
        logic [6:0] s;
        s = {1'b0, lv[5:0]} + {1'b0, fa};
        if (s > {1'b0, LVL_MAX}) s = {1'b0, LVL_MAX};
        return (fa == 6'd0) ? lv : {lv[7:6], s[5:0]};
    endfunction

endpackage

### design/fmwf_ctrl.sv
// ----------------------------------------------------------------------------
// FM register write filter controller
// Sequences the write update, the level and pan scans and the final transfer.
// ----------------------------------------------------------------------------
module fmwf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  fmwf_pkg::fmwf_sts_t sts,
    output fmwf_pkg::fmwf_cmd_t cmd
);
    import fmwf_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    if (sts.req_func == FUNC_WRITE && sts.req_bank_ok) state_next = S_WRITE;
                    else if (sts.req_func == FUNC_LEVELS) state_next = S_LVL_RD;
                    else if (sts.req_func == FUNC_PANS) state_next = S_PAN;
                    else state_next = S_IDLE;
                end
            end
            S_WRITE:  state_next = sts.refresh ? S_LVL_RD : S_FINAL;
            S_LVL_RD: state_next = S_LVL_EV;
            S_LVL_EV: begin
                if (!sts.lvl_last) state_next = S_LVL_RD;
                else if (sts.is_write) state_next = S_FINAL;
                else state_next = S_FLUSH;
            end
            S_PAN:    state_next = sts.pan_last ? S_FLUSH : S_PAN;
            S_FINAL:  state_next = S_FLUSH;
            S_FLUSH:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:   cmd.load = start;
            S_WRITE:  cmd.apply = 1'b1;
            S_LVL_RD: cmd.lvl_rd = 1'b1;
            S_LVL_EV: cmd.lvl_ev = 1'b1;
            S_PAN:    cmd.pan_step = 1'b1;
            S_FINAL:  cmd.final_push = 1'b1;
            S_FLUSH:  cmd.flush = 1'b1;
            default:  cmd = '0;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### design/fmwf_dp.sv
// ----------------------------------------------------------------------------
// FM register write filter datapath
// Configuration, shadow state, level memory, scan counter and output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fmwf_dp #(
    parameter int BANKS    = 2,
    parameter int CHANNELS = 18
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          func,
    input  logic                bank,
    input  logic [7:0]          reg_addr,
    input  logic [7:0]          reg_data,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [17:0]         cfg_data,
    input  fmwf_pkg::fmwf_cmd_t cmd,
    output fmwf_pkg::fmwf_sts_t sts,
    output logic                out_strobe,
    output logic                out_bank,
    output logic [7:0]          out_reg,
    output logic [7:0]          out_value,
    output logic                out_last
);
    import fmwf_pkg::*;

    logic [1:0]  emu_reg;
    logic [17:0] mute_reg;
    logic        silence_reg;
    logic [5:0]  fade_reg;

    logic [5:0]  fe_reg;
    logic [17:0] conn_reg;
    logic        drum_reg;
    logic [7:0]  pan_reg [18];
    logic [7:0]  lvl_mem [36];
    logic [35:0] lvl_vld_reg;
    logic [7:0]  lvl_q_reg;
    logic        lvl_vq_reg;

    logic [1:0]  func_reg;
    logic        bank_reg;
    logic [7:0]  addr_reg;
    logic [7:0]  val_reg;
    logic        drop_reg;

    logic        sb_reg;
    logic [4:0]  soff_reg;

    logic        pend_vld_reg;
    logic        pend_bank_reg;
    logic [7:0]  pend_reg_reg;
    logic [7:0]  pend_val_reg;

    logic        ostb_reg;
    logic        obank_reg;
    logic [7:0]  oreg_reg;
    logic [7:0]  oval_reg;
    logic        olast_reg;

    logic [7:0]  fix_val;
    logic        fix_drop;
    logic        in_wave;

    logic        c_mode, c_fourop, c_conn, c_lvl, c_drum;
    logic [3:0]  off9;
    logic [4:0]  wch;
    logic        wch_ok;
    logic [17:0] conn_new;
    logic [7:0]  lr;
    logic [4:0]  wlo;
    logic [5:0]  waddr;
    logic        lvl_ok;
    logic        conn_chg;
    logic        drum_chg;
    logic [7:0]  w_val;
    logic        w_drop;
    logic        w_refresh;

    logic [5:0]  raddr;
    logic [4:0]  pch;
    logic        cand_vld;
    logic        cand_bank;
    logic [7:0]  cand_reg;
    logic [7:0]  cand_val;
    logic [7:0]  lvl_rdata;
    logic [7:0]  ppan;
    logic        push;
    logic        scan_last;
    logic [4:0]  scan_end;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            emu_reg     <= '0;
            mute_reg    <= '1;
            silence_reg <= 1'b0;
            fade_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_EMU:     emu_reg <= cfg_data[1:0];
                CFG_MUTE:    mute_reg <= cfg_data;
                CFG_SILENCE: silence_reg <= cfg_data[0];
                CFG_FADE:    fade_reg <= cfg_data[5:0];
                default:     emu_reg <= emu_reg;
            endcase
        end
    end

    always_comb begin
        in_wave = (reg_addr >= REG_WAVE_LO) && (reg_addr <= REG_WAVE_HI);
        fix_val = reg_data;
        fix_drop = 1'b0;
        if (emu_reg == EMU_GEN1) begin
            if (reg_addr == REG_TEST) fix_val[5] = 1'b0;
            fix_drop = in_wave;
        end
        if ((emu_reg == EMU_GEN2 || emu_reg == EMU_GEN1) && !fix_drop) begin
            if (reg_addr >= REG_CONN_LO && reg_addr <= REG_CONN_HI) fix_val[5:4] = 2'b11;
            if (in_wave) fix_val[2] = 1'b0;
        end
    end

    always_comb begin
        c_mode   = bank_reg && (addr_reg == REG_MODE);
        c_fourop = bank_reg && (addr_reg == REG_FOUROP);
        c_conn   = (addr_reg >= REG_CONN_LO) && (addr_reg <= REG_CONN_HI);
        c_lvl    = (addr_reg >= REG_LVL_LO) && (addr_reg <= REG_LVL_HI);
        c_drum   = !bank_reg && (addr_reg == REG_DRUM);
        off9     = 4'(addr_reg - REG_CONN_LO);
        wch      = (bank_reg ? 5'd9 : 5'd0) + {1'b0, off9};
        wch_ok   = (32'(wch) < CHANNELS);
        conn_new = conn_reg;
        conn_new[wch] = val_reg[0];
        lr       = addr_reg - REG_LVL_LO;
        lvl_ok   = (lr[2:0] < 3'd6);
        wlo      = (lr[4:3] == 2'd2) ? 5'd12 : ((lr[4:3] == 2'd1) ? 5'd6 : 5'd0);
        wlo      = wlo + {2'b0, lr[2:0]};
        waddr    = (bank_reg ? 6'd18 : 6'd0) + {1'b0, wlo};
        conn_chg = chan_algo(bank_reg, off9, fe_reg, conn_reg)
                != chan_algo(bank_reg, off9, fe_reg, conn_new);
        drum_chg = (val_reg[5] != drum_reg);
        w_val    = val_reg;
        w_drop   = drop_reg;
        w_refresh = 1'b0;
        if (!drop_reg) begin
            priority if (c_mode || c_fourop) begin
                w_val = val_reg;
            end else if (c_conn) begin
                if (!wch_ok) begin
                    w_drop = 1'b1;
                end else begin
                    w_refresh = conn_chg;
                    if (!mute_reg[wch] || silence_reg) w_val[7:4] = 4'h0;
                end
            end else if (c_lvl) begin
                if (!lvl_ok) w_drop = 1'b1;
                else if (is_output(bank_reg, wlo, fe_reg, conn_reg, drum_reg))
                    w_val = apply_fade(val_reg, fade_reg);
            end else if (c_drum) begin
                w_refresh = drum_chg;
            end else begin
                w_val = val_reg;
            end
        end
    end

    assign scan_end  = (cmd.pan_step) ? CH_LAST : OP_LAST;
    assign scan_last = (sb_reg == 1'(BANKS - 1)) && (soff_reg == scan_end);
    assign raddr     = (sb_reg ? 6'd18 : 6'd0) + {1'b0, soff_reg};
    assign pch       = (sb_reg ? 5'd9 : 5'd0) + soff_reg;
    assign lvl_rdata = lvl_vq_reg ? lvl_q_reg : 8'h00;

    always_comb begin
        ppan = pan_reg[pch];
        if (!mute_reg[pch] || silence_reg) ppan[7:4] = 4'h0;
    end

    always_comb begin
        cand_vld  = 1'b0;
        cand_bank = sb_reg;
        cand_reg  = level_reg(soff_reg);
        cand_val  = apply_fade(lvl_rdata, fade_reg);
        if (cmd.lvl_ev) begin
            cand_vld = is_output(sb_reg, soff_reg, fe_reg, conn_reg, drum_reg);
        end else if (cmd.pan_step) begin
            cand_vld = (32'(pch) < CHANNELS);
            cand_reg = REG_CONN_LO + {3'b0, soff_reg};
            cand_val = ppan;
        end else if (cmd.final_push) begin
            cand_vld  = !drop_reg;
            cand_bank = bank_reg;
            cand_reg  = addr_reg;
            cand_val  = val_reg;
        end
    end

    assign push = cand_vld;

    assign sts.req_func    = func;
    assign sts.req_bank_ok = (32'(bank) < BANKS);
    assign sts.refresh     = w_refresh;
    assign sts.lvl_last    = scan_last;
    assign sts.pan_last    = scan_last;
    assign sts.is_write    = (func_reg == FUNC_WRITE);

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            func_reg <= func;
            bank_reg <= bank;
            addr_reg <= reg_addr;
            val_reg  <= fix_val;
            drop_reg <= fix_drop;
        end else if (cmd.apply) begin
            val_reg  <= w_val;
            drop_reg <= w_drop;
        end
        if (cmd.apply && !drop_reg && c_lvl && lvl_ok) lvl_mem[waddr] <= val_reg;
        if (cmd.lvl_rd) lvl_q_reg <= lvl_mem[raddr];
        if (push) begin
            pend_bank_reg <= cand_bank;
            pend_reg_reg  <= cand_reg;
            pend_val_reg  <= cand_val;
        end
        obank_reg <= pend_bank_reg;
        oreg_reg  <= pend_reg_reg;
        oval_reg  <= pend_val_reg;
        olast_reg <= cmd.flush;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fe_reg       <= '0;
            conn_reg     <= '0;
            drum_reg     <= 1'b0;
            lvl_vld_reg  <= '0;
            lvl_vq_reg   <= 1'b0;
            sb_reg       <= 1'b0;
            soff_reg     <= '0;
            pend_vld_reg <= 1'b0;
            ostb_reg     <= 1'b0;
            for (int i = 0; i < 18; i++) pan_reg[i] <= PAN_RESET;
        end else begin
            if (cmd.apply && !drop_reg) begin
                priority if (c_mode) begin
                    fe_reg <= fe_reg;
                end else if (c_fourop) begin
                    fe_reg <= val_reg[5:0];
                end else if (c_conn) begin
                    if (wch_ok) conn_reg <= conn_new;
                end else if (c_lvl) begin
                    if (lvl_ok) lvl_vld_reg[waddr] <= 1'b1;
                end else if (c_drum) begin
                    drum_reg <= val_reg[5];
                end else begin
                    fe_reg <= fe_reg;
                end
            end
            if (cmd.apply && !drop_reg && c_conn && wch_ok) pan_reg[wch] <= val_reg;
            if (cmd.lvl_rd) lvl_vq_reg <= lvl_vld_reg[raddr];
            if (cmd.load) begin
                sb_reg   <= 1'b0;
                soff_reg <= '0;
            end else if (cmd.lvl_ev || cmd.pan_step) begin
                if (soff_reg == scan_end) begin
                    soff_reg <= '0;
                    sb_reg   <= scan_last ? 1'b0 : ~sb_reg;
                end else begin
                    soff_reg <= soff_reg + 5'd1;
                end
            end
            ostb_reg <= pend_vld_reg && (push || cmd.flush);
            if (cmd.flush) pend_vld_reg <= 1'b0;
            else if (push) pend_vld_reg <= 1'b1;
        end
    end

    assign out_strobe = ostb_reg;
    assign out_bank   = obank_reg;
    assign out_reg    = oreg_reg;
    assign out_value  = oval_reg;
    assign out_last   = olast_reg;

    `ASSERT_NEXT(a_flush_last, cmd.flush && pend_vld_reg, out_strobe && out_last)
    `ASSERT_NEXT(a_push_notlast, push && pend_vld_reg, out_strobe && !out_last)
    `ASSERT_NEXT(a_last_gap, out_strobe && out_last, !out_strobe)

endmodule

### design/fm_synth_register_write_filter.sv
// A plain write steps through the load, apply, final and flush states; a pan refresh
// steps through each channel and then flushes, and a level refresh steps through each
// operator slot with one level memory read and one check per slot before the flush.
// A write that changes an algorithm or the drum mode adds the level refresh.
// Reset is asynchronous and restores configuration, shadows and controller at once.
// Results are transferred one per strobe cycle and are never stalled by the receiver.
// ----------------------------------------------------------------------------
// FM synthesizer register write filter
// Filters chip register writes through shadow state, mute, silence and fade, and replays levels and pans on request.
// ----------------------------------------------------------------------------
module fm_synth_register_write_filter #(
    parameter int BANKS    = 2,
    parameter int CHANNELS = 18
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic        bank,
    input  logic [7:0]  reg_addr,
    input  logic [7:0]  reg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data,
    output logic        out_strobe,
    output logic        out_bank,
    output logic [7:0]  out_reg,
    output logic [7:0]  out_value,
    output logic        out_last
);
    import fmwf_pkg::*;

    fmwf_cmd_t cmd;
    fmwf_sts_t sts;

    assign cfg_ready = 1'b1;

    fmwf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    fmwf_dp #(
        .BANKS    (BANKS),
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .func       (func),
        .bank       (bank),
        .reg_addr   (reg_addr),
        .reg_data   (reg_data),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .out_strobe (out_strobe),
        .out_bank   (out_bank),
        .out_reg    (out_reg),
        .out_value  (out_value),
        .out_last   (out_last)
    );

endmodule
